// File: rtl/core/lrcc_pkg.sv
package lrcc_pkg;

  localparam logic [31:0] CrcPoly        = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes        = 32'hFFFF_FFFF;
  localparam logic [31:0] MaxLengthReset = 32'd1048576;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    VD_VALID         = 3'd0,
    VD_SHORT_HEADER  = 3'd1,
    VD_TOO_LONG      = 3'd2,
    VD_SHORT_PAYLOAD = 3'd3,
    VD_CRC_MISMATCH  = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_log;
  } item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] payload_length;
    logic [31:0] computed_crc;
  } result_t;

  // reflected CRC-32, one byte, unfinalized
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] t;
    t = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      t = t[0] ? (CrcPoly ^ (t >> 1)) : (t >> 1);
    end
    return t ^ (crc >> 8);
  endfunction

endpackage

// File: rtl/core/lrcc_in_stage.sv
module lrcc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lrcc_pkg::item_t    item_i,
  output logic               item_valid_o,
  input  logic               item_take_i,
  output lrcc_pkg::item_t    item_o
);

  logic            valid_q, valid_d;
  lrcc_pkg::item_t item_q;

  assign in_ready_o   = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// File: rtl/core/lrcc_core.sv
module lrcc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               item_valid_i,
  output logic               item_take_o,
  input  lrcc_pkg::item_t    item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lrcc_pkg::result_t  result_o
);

  logic [31:0]       max_len_q;
  lrcc_pkg::phase_e  phase_q, phase_d;
  logic [31:0]       cnt_q, cnt_d;
  logic [31:0]       len_q, len_d;
  logic [31:0]       chk_q, chk_d;
  logic [31:0]       crc_q, crc_d;
  logic              out_valid_q, out_valid_d;
  lrcc_pkg::result_t res_q, res_d;

  logic [31:0] cnt_inc;
  logic [31:0] crc_new;
  logic [31:0] fin;
  logic        emit;
  logic        rearm;
  logic [7:0]  b;
  logic        eol;

  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign b           = item_i.data_byte;
  assign eol         = item_i.end_of_log;
  assign cnt_inc     = cnt_q + 32'd1;
  assign crc_new     = lrcc_pkg::crc_byte(crc_q, b);
  assign fin         = ~crc_new;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    chk_d   = chk_q;
    crc_d   = crc_q;
    emit    = 1'b0;
    rearm   = 1'b0;
    res_d   = res_q;
    if (item_take_o) begin
      unique case (phase_q)
        lrcc_pkg::PH_HEADER: begin
          if (cnt_q < 32'd4) begin
            len_d = {len_q[23:0], b};
          end else begin
            chk_d = {chk_q[23:0], b};
          end
          cnt_d = cnt_inc;
          if (cnt_inc == 32'd4 && len_d > max_len_q) begin
            emit  = 1'b1;
            res_d = '{lrcc_pkg::VD_TOO_LONG, len_d, 32'd0};
          end else if (cnt_inc == 32'd8) begin
            if (len_q == 32'd0) begin
              emit  = 1'b1;
              res_d = '{(chk_d == 32'd0) ? lrcc_pkg::VD_VALID : lrcc_pkg::VD_CRC_MISMATCH,
                        32'd0, 32'd0};
            end else begin
              phase_d = lrcc_pkg::PH_PAYLOAD;
              cnt_d   = 32'd0;
              if (eol) begin
                emit  = 1'b1;
                res_d = '{lrcc_pkg::VD_SHORT_PAYLOAD, len_q, 32'd0};
              end
            end
          end else if (eol) begin
            emit  = 1'b1;
            res_d = '{lrcc_pkg::VD_SHORT_HEADER, 32'd0, 32'd0};
          end
        end
        lrcc_pkg::PH_PAYLOAD: begin
          crc_d = crc_new;
          cnt_d = cnt_inc;
          if (cnt_inc == len_q) begin
            emit  = 1'b1;
            res_d = '{(fin == chk_q) ? lrcc_pkg::VD_VALID : lrcc_pkg::VD_CRC_MISMATCH,
                      len_q, fin};
          end else if (eol) begin
            emit  = 1'b1;
            res_d = '{lrcc_pkg::VD_SHORT_PAYLOAD, len_q, fin};
          end
        end
        default: begin
          rearm = eol;
        end
      endcase
      if (emit) begin
        if (eol) begin
          rearm = 1'b1;
        end else begin
          phase_d = lrcc_pkg::PH_DONE;
        end
      end
    end
    if (rearm) begin
      phase_d = lrcc_pkg::PH_HEADER;
      cnt_d   = 32'd0;
      len_d   = 32'd0;
      chk_d   = 32'd0;
      crc_d   = lrcc_pkg::CrcOnes;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= lrcc_pkg::MaxLengthReset;
      phase_q     <= lrcc_pkg::PH_HEADER;
      cnt_q       <= 32'd0;
      len_q       <= 32'd0;
      chk_q       <= 32'd0;
      crc_q       <= lrcc_pkg::CrcOnes;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      chk_q       <= chk_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

endmodule

// File: rtl/core/log_record_crc_checker.sv
// Datapath: an accepted byte passes the input register, then the state update into the
//   result register, before its verdict reaches the outputs.
// Throughput: one byte per cycle while no verdict waits; the bytewise CRC update is combinational.
//   The input stalls only while a verdict waits in the result register for out_ready_i.
// Reset (rst_ni, async, active low): header phase, counters and header fields zero,
//   CRC all ones, max_length 1048576, no request or result pending.
module log_record_crc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_log_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  verdict_o,
  output logic [31:0] payload_length_o,
  output logic [31:0] computed_crc_o
);

  lrcc_pkg::item_t   item_in;
  lrcc_pkg::item_t   item_reg;
  logic              item_valid;
  logic              item_take;
  lrcc_pkg::result_t result;

  assign item_in = '{data_byte_i, end_of_log_i};

  lrcc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (item_in),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item_reg)
  );

  lrcc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item_reg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign verdict_o        = 3'(result.verdict);
  assign payload_length_o = result.payload_length;
  assign computed_crc_o   = result.computed_crc;

endmodule

// File: tb/lrcc_verdict_checker.sv
`timescale 1ns / 100ps
module lrcc_verdict_checker
  import lrcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_log_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  verdict_i,
  input  logic [31:0] payload_length_i,
  input  logic [31:0] computed_crc_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  phase_e      rec_phase;
  logic [31:0] rec_count;
  logic [31:0] rec_len;
  logic [31:0] rec_crc_field;
  logic [31:0] rec_crc;
  logic [31:0] len_limit;
  result_t     verdict_q[$];
  int          fail_count   = 0;
  int          verdicts_ok  = 0;
  int          expected_cnt = 0;

  assign errors_o  = fail_count;
  assign pending_o = expected_cnt;
  assign checked_o = verdicts_ok;

  function automatic logic [31:0] crc32_shift(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  task automatic rearm_record();
    rec_phase     = PH_HEADER;
    rec_count     = '0;
    rec_len       = '0;
    rec_crc_field = '0;
    rec_crc       = CrcOnes;
  endtask

  task automatic post_verdict(input verdict_e v, input logic [31:0] l, input logic [31:0] c,
                              input logic eol);
    result_t r;
    r.verdict        = v;
    r.payload_length = l;
    r.computed_crc   = c;
    verdict_q.push_back(r);
    if (eol) begin
      rearm_record();
    end else begin
      rec_phase = PH_DONE;
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic eol);
    logic [31:0] fin;
    case (rec_phase)
      PH_HEADER: begin
        if (rec_count < 32'd4) begin
          rec_len = {rec_len[23:0], b};
        end else begin
          rec_crc_field = {rec_crc_field[23:0], b};
        end
        rec_count++;
        if (rec_count == 32'd4 && rec_len > len_limit) begin
          post_verdict(VD_TOO_LONG, rec_len, '0, eol);
        end else if (rec_count == 32'd8) begin
          if (rec_len == '0) begin
            post_verdict((rec_crc_field == '0) ? VD_VALID : VD_CRC_MISMATCH, '0, '0, eol);
          end else begin
            rec_phase = PH_PAYLOAD;
            rec_count = '0;
            if (eol) post_verdict(VD_SHORT_PAYLOAD, rec_len, '0, 1'b1);
          end
        end else if (eol) begin
          post_verdict(VD_SHORT_HEADER, '0, '0, 1'b1);
        end
      end
      PH_PAYLOAD: begin
        rec_crc = crc32_shift(rec_crc, b);
        rec_count++;
        fin = rec_crc ^ CrcOnes;
        if (rec_count == rec_len) begin
          post_verdict((fin == rec_crc_field) ? VD_VALID : VD_CRC_MISMATCH, rec_len, fin, eol);
        end else if (eol) begin
          post_verdict(VD_SHORT_PAYLOAD, rec_len, fin, 1'b1);
        end
      end
      default: begin
        if (eol) rearm_record();
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_result();
    result_t exp_r;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("unexpected verdict %0d len %08h crc %08h",
                                verdict_i, payload_length_i, computed_crc_i));
    end else begin
      exp_r = verdict_q.pop_front();
      verdicts_ok++;
      if (verdict_i != exp_r.verdict)
        report_mismatch($sformatf("verdict %0d, want %0d", verdict_i, exp_r.verdict));
      if (payload_length_i != exp_r.payload_length)
        report_mismatch($sformatf("payload_length %08h, want %08h",
                                  payload_length_i, exp_r.payload_length));
      if (computed_crc_i != exp_r.computed_crc)
        report_mismatch($sformatf("computed_crc %08h, want %08h",
                                  computed_crc_i, exp_r.computed_crc));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_limit = MaxLengthReset;
      rearm_record();
      verdict_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) compare_result();
      if (cfg_we_i) len_limit = cfg_wdata_i;
      if (in_valid_i && in_ready_i) absorb_byte(data_byte_i, end_of_log_i);
    end
    expected_cnt = verdict_q.size();
  end

endmodule

// File: tb/tb_log_record_crc_checker.sv
`timescale 1ns / 100ps
module tb_log_record_crc_checker;
  import lrcc_pkg::*;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  localparam int RandBytesPerPhase = 290;
  localparam int NumPhases         = 5;
  localparam int LongHoldCycles    = 400;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [31:0] cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  data_byte_i  = '0;
  logic        end_of_log_i = 1'b0;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  verdict_o;
  logic [31:0] payload_length_o;
  logic [31:0] computed_crc_o;

  int          errors;
  int          pending;
  int          checked;

  logic [7:0]  log_q[$];
  logic [31:0] cur_limit  = MaxLengthReset;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          logs_sent  = 0;
  int          cfg_writes = 0;
  bit          hold_req   = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  log_record_crc_checker i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_log_i     (end_of_log_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .verdict_o        (verdict_o),
    .payload_length_o (payload_length_o),
    .computed_crc_o   (computed_crc_o)
  );

  lrcc_verdict_checker i_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_log_i     (end_of_log_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .verdict_i        (verdict_o),
    .payload_length_i (payload_length_o),
    .computed_crc_i   (computed_crc_o),
    .errors_o         (errors),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  task automatic drive_byte(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(9, 1);
      burst_left = $urandom_range(48, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    end_of_log_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) log_q.push_back(w[8*k +: 8]);
  endtask

  task automatic push_junk(input int n);
    for (int k = 0; k < n; k++) log_q.push_back(8'($urandom));
  endtask

  task automatic build_record(input logic [31:0] len, input int n_pay, input bit bad_crc);
    logic [31:0] c;
    logic [7:0]  pay[$];
    logic [7:0]  b;
    c = CrcOnes;
    for (int k = 0; k < n_pay; k++) begin
      b = 8'($urandom);
      pay.push_back(b);
      c = crc_byte(c, b);
    end
    c = c ^ CrcOnes;
    if (bad_crc) c = c ^ (32'd1 << $urandom_range(31, 0));
    push_word(len);
    push_word(c);
    foreach (pay[k]) log_q.push_back(pay[k]);
  endtask

  task automatic send_log();
    for (int k = 0; k < log_q.size(); k++) drive_byte(log_q[k], k == log_q.size() - 1);
    log_q.delete();
    logs_sent++;
  endtask

  task automatic make_random_log();
    int          pick;
    int          n;
    logic [31:0] len;
    pick = $urandom_range(99, 0);
    if (pick < 65) begin
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
      build_record(n, n, pick >= 50);
      push_junk($urandom_range(3, 0));
    end else if (pick < 73) begin
      build_record('0, 0, $urandom_range(1, 0));
      push_junk($urandom_range(3, 0));
    end else if (pick < 81 && cur_limit != 32'hFFFF_FFFF) begin
      len = $urandom;
      if (len <= cur_limit) len = cur_limit + 32'd1 + (len % (32'hFFFF_FFFF - cur_limit));
      push_word(len);
      push_junk($urandom_range(6, 0));
    end else if (pick < 88) begin
      push_junk($urandom_range(7, 1));
    end else if (pick < 95 || pick < 81) begin
      len = $urandom_range(1, 0) ? 32'($urandom_range(20, 2)) : 32'($urandom);
      if (len < 32'd2) len = 32'd2;
      n = (len > 32'd21) ? $urandom_range(20, 0) : $urandom_range(int'(len) - 1, 0);
      build_record(len, n, 1'b0);
    end else begin
      push_junk($urandom_range(24, 1));
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_limit   = v;
    cfg_writes++;
  endtask

  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHoldCycles;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(3, 0));
        mode_left = $urandom_range(200, 20);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(1, 0));
          RX_SPARSE: out_ready_i <= ($urandom_range(3, 0) == 0);
          default:   out_ready_i <= ((mode_left % 5) < 3);
        endcase
      end
    end
  end

  initial begin
    logic [31:0] limits[NumPhases];
    int          base;
    limits[0] = 32'd0;
    limits[1] = 32'hFFFF_FFFF;
    limits[2] = 32'($urandom_range(24, 1));
    limits[3] = 32'($urandom);
    limits[4] = MaxLengthReset;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    log_q.push_back(8'hFF);
    send_log();
    push_word(32'hFFFF_FFFF);
    send_log();
    push_word('0);
    push_word(32'h0000_0001);
    send_log();
    push_word(32'd2);
    push_word(32'($urandom));
    send_log();
    build_record(32'd1, 1, 1'b0);
    send_log();

    base = bytes_sent;
    for (int p = 0; p < NumPhases; p++) begin
      write_limit(limits[p]);
      if (p == 0) hold_req = 1'b1;
      while (bytes_sent - base < (p + 1) * RandBytesPerPhase) begin
        make_random_log();
        send_log();
      end
    end

    settle();
    $display("covered %0d bytes in %0d logs under %0d length limits",
             bytes_sent, logs_sent, cfg_writes);
    $display("%0d verdicts compared, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("log_record_crc_checker regression: pass");
    end else begin
      $display("log_record_crc_checker regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("log_record_crc_checker regression: fail");
    $finish;
  end

endmodule
